@@ hdl/ipsfc_pkg.sv @@
// Package: shared types, codes and pixel format helpers for the image pixel store.
`default_nettype none

package ipsfc_pkg;

    // Access codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_READ        = 2'd0,
        OP_WRITE_RAW   = 2'd1,
        OP_WRITE_COLOR = 2'd2,
        OP_NOP         = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH      = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT     = 2'd1;
    localparam logic [1:0] CFG_PIXEL_COMPONENTS = 2'd2;

    // Pixel formats, by bytes per pixel
    localparam logic [2:0] FMT_GRAY       = 3'd1;
    localparam logic [2:0] FMT_GRAY_ALPHA = 3'd2;
    localparam logic [2:0] FMT_RGB        = 3'd3;
    localparam logic [2:0] FMT_RGBA       = 3'd4;

    localparam logic [7:0] OPAQUE_ALPHA = 8'd255;
    // 683 / 2048 rounds sums below 2048 down to exactly sum / 3
    localparam logic [9:0] THIRD_RECIP  = 10'd683;

    typedef struct packed {
        logic [31:0] raw;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } view_t;

    function automatic logic [31:0] comp_mask(input logic [2:0] comps);
        logic [31:0] mask;
        unique case (comps)
            FMT_GRAY:       mask = 32'h0000_00FF;
            FMT_GRAY_ALPHA: mask = 32'h0000_FFFF;
            FMT_RGB:        mask = 32'h00FF_FFFF;
            FMT_RGBA:       mask = 32'hFFFF_FFFF;
            default:        mask = 32'h0000_0000;
        endcase
        return mask;
    endfunction

    function automatic logic fmt_valid(input logic [2:0] comps);
        return (comps == FMT_GRAY) || (comps == FMT_GRAY_ALPHA) ||
               (comps == FMT_RGB) || (comps == FMT_RGBA);
    endfunction

    // Colour write packing; gray is the mean of r, g and b, rounded down
    function automatic logic [31:0] pack_color(input logic [2:0] comps,
                                               input logic [7:0] r,
                                               input logic [7:0] g,
                                               input logic [7:0] b,
                                               input logic [7:0] a);
        logic [9:0]  sum;
        logic [19:0] prod;
        logic [7:0]  gray;
        logic [31:0] val;
        sum  = 10'(r) + 10'(g) + 10'(b);
        prod = sum * THIRD_RECIP;
        gray = prod[18:11];
        unique case (comps)
            FMT_GRAY:       val = {24'd0, gray};
            FMT_GRAY_ALPHA: val = {16'd0, gray, a};
            FMT_RGB:        val = {8'd0, r, g, b};
            default:        val = {r, g, b, a};
        endcase
        return val;
    endfunction

    // RGBA view of a stored entry under the current format
    function automatic view_t unpack_pixel(input logic [2:0] comps,
                                           input logic [31:0] entry);
        logic [31:0] px;
        view_t       v;
        px      = entry & comp_mask(comps);
        v.raw   = px;
        v.red   = 8'd0;
        v.green = 8'd0;
        v.blue  = 8'd0;
        v.alpha = OPAQUE_ALPHA;
        unique case (comps)
            FMT_GRAY: begin
                v.red   = px[7:0];
                v.green = px[7:0];
                v.blue  = px[7:0];
            end
            FMT_GRAY_ALPHA: begin
                v.red   = px[15:8];
                v.green = px[15:8];
                v.blue  = px[15:8];
                v.alpha = px[7:0];
            end
            FMT_RGB: begin
                v.red   = px[23:16];
                v.green = px[15:8];
                v.blue  = px[7:0];
            end
            FMT_RGBA: begin
                v.red   = px[31:24];
                v.green = px[23:16];
                v.blue  = px[15:8];
                v.alpha = px[7:0];
            end
            default: begin
                v.raw = 32'd0;
            end
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hdl/image_pixel_store_format_convert.sv @@
// Top level: image pixel store with raw and colour access and format conversion.
//
// Channel   Dir  Handshake               Content
// s_*       in   s_tvalid / s_tready     one access: op in tuser, coords and data in tdata
// m_*       out  m_tvalid / m_tready     one result per access, out-of-bounds flag in tuser
// cfg_*     in   cfg_valid / cfg_ready   register index and write data
//
// One access per cycle is taken while s_tready is high; its result passes
// through the registered read of the single RAM port (one read or one write
// per access) and stage 1 into the output register, and leaves when m_tready is high.
// A write followed at once by a read of the same pixel sees the new value,
// as the port orders them.
// Reset (aresetn low, synchronous) clears the configuration registers and
// pipeline valids; the store itself is not cleared and needs no sweep. A
// stalled output holds the middle stage, which in turn drops s_tready.
`default_nettype none

module image_pixel_store_format_convert
    import ipsfc_pkg::*;
#(
    parameter int MAX_SIDE = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input access stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [9:0] x_coord, [19:10] y_coord, [51:20] raw_value, [59:52] red_in,
    // [67:60] green_in, [75:68] blue_in, [83:76] alpha_in, [87:84] zero
    input  wire logic [87:0] s_tdata,
    // [1:0] operation
    input  wire logic [1:0]  s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] raw_pixel, [39:32] red_out, [47:40] green_out,
    // [55:48] blue_out, [63:56] alpha_out
    output logic [63:0]      m_tdata,
    // [0] out_of_bounds
    output logic [0:0]       m_tuser,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ---------------- configuration registers ----------------
    logic [8:0] width_reg,  width_next;
    logic [8:0] height_reg, height_next;
    logic [2:0] comps_reg,  comps_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        comps_next  = comps_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:      width_next  = cfg_data;
                CFG_IMAGE_HEIGHT:     height_next = cfg_data;
                CFG_PIXEL_COMPONENTS: comps_next  = cfg_data[2:0];
                default: ;  // index beyond the register list: ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= '0;
            height_reg <= '0;
            comps_reg  <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            comps_reg  <= comps_next;
        end
    end

    // ---------------- input field split ----------------
    op_t               in_op;
    logic signed [9:0] x_s;
    logic signed [9:0] y_s;
    logic [31:0]       raw_in;
    logic [7:0]        red_in, green_in, blue_in, alpha_in;

    assign in_op    = op_t'(s_tuser);
    assign x_s      = $signed(s_tdata[9:0]);
    assign y_s      = $signed(s_tdata[19:10]);
    assign raw_in   = s_tdata[51:20];
    assign red_in   = s_tdata[59:52];
    assign green_in = s_tdata[67:60];
    assign blue_in  = s_tdata[75:68];
    assign alpha_in = s_tdata[83:76];

    // ---------------- address and bounds ----------------
    // idx = y * width + x, signed; area = width * height
    logic signed [9:0]  w_s;
    logic signed [19:0] row_base;
    logic signed [20:0] idx;
    logic [17:0]        area;
    logic [31:0]        idx_u;
    logic               in_oob;

    assign w_s      = $signed({1'b0, width_reg});
    assign row_base = y_s * w_s;
    assign idx      = 21'(row_base) + 21'(x_s);
    assign area     = width_reg * height_reg;
    assign idx_u    = {12'd0, idx[19:0]};
    assign in_oob   = idx[20] || (idx[19:0] >= 20'(area)) || (idx_u >= 32'(DEPTH));

    // ---------------- pipeline control ----------------
    logic        s1_valid_reg, s1_valid_next;
    op_t         s1_op_reg;
    logic        s1_oob_reg;
    logic [2:0]  s1_comps_reg;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_tdata_reg;
    logic        m_oob_reg;

    logic accept;
    logic out_free;
    logic advance;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // ---------------- store access ----------------
    logic              is_write;
    logic              ram_we;
    logic [31:0]       write_val;
    logic [31:0]       ram_rdata;

    assign is_write  = (in_op == OP_WRITE_RAW) || (in_op == OP_WRITE_COLOR);
    assign ram_we    = is_write && !in_oob && fmt_valid(comps_reg);
    assign write_val = ((in_op == OP_WRITE_RAW) ? raw_in
                        : pack_color(comps_reg, red_in, green_in, blue_in, alpha_in))
                       & comp_mask(comps_reg);

    // port enabled on every transfer; a read-only cycle refreshes read data
    ipsfc_ram #(
        .DATA_W (32),
        .DEPTH  (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .en    (accept),
        .we    (ram_we),
        .addr  (idx_u[ADDR_W-1:0]),
        .wdata (write_val),
        .rdata (ram_rdata)
    );

    // ---------------- stage 1: waits for read data ----------------
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg    <= in_op;
            s1_oob_reg   <= in_oob;
            s1_comps_reg <= comps_reg;
        end
    end

    // ---------------- result formation ----------------
    view_t       rd_view;
    logic [63:0] res_tdata;
    logic        res_oob;

    assign rd_view = unpack_pixel(s1_comps_reg, ram_rdata);

    always_comb begin
        res_tdata = '0;
        res_oob   = 1'b0;
        case (s1_op_reg)
            OP_NOP: ;  // nothing done, all-zero result
            OP_READ: begin
                res_oob = s1_oob_reg;
                if (!s1_oob_reg) begin
                    res_tdata = {rd_view.alpha, rd_view.blue, rd_view.green,
                                 rd_view.red, rd_view.raw};
                end
            end
            default: begin
                res_oob = s1_oob_reg;
            end
        endcase
    end

    // ---------------- output register ----------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= res_tdata;
            m_oob_reg   <= res_oob;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_oob_reg;

endmodule

`default_nettype wire

@@ hdl/ipsfc_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none

module ipsfc_ram #(
    parameter  int DATA_W = 32,
    parameter  int DEPTH  = 65536,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // read data holds while the port is idle or writing
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_array[addr] <= wdata;
            end else begin
                rdata_reg <= mem_array[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ verif/ipsfc_tb_pkg.sv @@
// Scoreboard package for the image pixel store testbench: access and view types, prediction.
`timescale 1ns / 1ps

package ipsfc_tb_pkg;
    import ipsfc_pkg::*;

    localparam int STORE_ENTRIES = 256 * 256;

    typedef struct {
        op_t         op;
        int          x;
        int          y;
        logic [31:0] raw;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } pixel_access_t;

    typedef struct packed {
        logic [31:0] raw;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        oob;
    } pixel_view_t;

    class pixel_access_scoreboard;
        int          width;
        int          height;
        logic [2:0]  comps;
        logic [31:0] image_copy [int];
        int          filled_idx [$];
        pixel_view_t expected_views [$];
        int          errors;
        int          views_seen;

        function new();
            width      = 0;
            height     = 0;
            comps      = 3'd0;
            errors     = 0;
            views_seen = 0;
        endfunction

        function void set_reg(logic [1:0] index, logic [8:0] value);
            case (index)
                CFG_IMAGE_WIDTH:      width  = int'(value);
                CFG_IMAGE_HEIGHT:     height = int'(value);
                CFG_PIXEL_COMPONENTS: comps  = value[2:0];
                default: ;
            endcase
        endfunction

        function bit format_valid();
            return comps >= FMT_GRAY && comps <= FMT_RGBA;
        endfunction

        function int pending();
            return expected_views.size();
        endfunction

        function bit inside_image(int x, int y);
            int idx;
            idx = y * width + x;
            return idx >= 0 && idx < width * height && idx < STORE_ENTRIES;
        endfunction

        // a read here would hit an entry never written
        function bit hits_unwritten(int x, int y);
            return inside_image(x, y) && !image_copy.exists(y * width + x);
        endfunction

        function logic [31:0] bytes_mask();
            case (comps)
                FMT_GRAY, FMT_GRAY_ALPHA, FMT_RGB, FMT_RGBA:
                    return 32'hFFFF_FFFF >> (8 * (4 - int'(comps)));
                default: return 32'd0;
            endcase
        endfunction

        // predict the view for one accepted access and update the image copy
        function void note_access(pixel_access_t acc);
            pixel_view_t v;
            int          idx;
            logic [31:0] px;
            logic [31:0] val;
            logic [7:0]  gray;
            v = '0;
            if (acc.op == OP_NOP) begin
                expected_views.push_back(v);
                return;
            end
            if (!inside_image(acc.x, acc.y)) begin
                v.oob = 1'b1;
                expected_views.push_back(v);
                return;
            end
            idx = acc.y * width + acc.x;
            if (acc.op == OP_READ) begin
                px      = image_copy.exists(idx) ? image_copy[idx] & bytes_mask() : 32'd0;
                v.raw   = px;
                v.alpha = 8'hFF;
                case (comps)
                    FMT_GRAY: begin
                        v.red = px[7:0]; v.green = px[7:0]; v.blue = px[7:0];
                    end
                    FMT_GRAY_ALPHA: begin
                        v.red = px[15:8]; v.green = px[15:8]; v.blue = px[15:8];
                        v.alpha = px[7:0];
                    end
                    FMT_RGB: begin
                        v.red = px[23:16]; v.green = px[15:8]; v.blue = px[7:0];
                    end
                    FMT_RGBA: begin
                        v.red = px[31:24]; v.green = px[23:16]; v.blue = px[15:8];
                        v.alpha = px[7:0];
                    end
                    default: ;
                endcase
            end else if (format_valid()) begin
                gray = 8'((int'(acc.red) + int'(acc.green) + int'(acc.blue)) / 3);
                if (acc.op == OP_WRITE_RAW) begin
                    val = acc.raw;
                end else begin
                    case (comps)
                        FMT_GRAY:       val = {24'd0, gray};
                        FMT_GRAY_ALPHA: val = {16'd0, gray, acc.alpha};
                        FMT_RGB:        val = {8'd0, acc.red, acc.green, acc.blue};
                        default:        val = {acc.red, acc.green, acc.blue, acc.alpha};
                    endcase
                end
                if (!image_copy.exists(idx))
                    filled_idx.push_back(idx);
                image_copy[idx] = val & bytes_mask();
            end
            expected_views.push_back(v);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("MISMATCH: %s", msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("view %0d %s: got %0h, expected %0h",
                                 views_seen, name, got, want));
        endtask

        task check_view(logic [63:0] data, logic oob);
            pixel_view_t want;
            if (expected_views.size() == 0) begin
                report($sformatf("view %0d arrived with nothing outstanding", views_seen));
                views_seen++;
                return;
            end
            want = expected_views.pop_front();
            compare_field("raw_pixel", data[31:0], want.raw);
            compare_field("red_out", data[39:32], want.red);
            compare_field("green_out", data[47:40], want.green);
            compare_field("blue_out", data[55:48], want.blue);
            compare_field("alpha_out", data[63:56], want.alpha);
            compare_field("out_of_bounds", oob, want.oob);
            views_seen++;
        endtask
    endclass

endpackage

@@ verif/tb_image_pixel_store_format_convert.sv @@
// Testbench top: directed and random pixel accesses with a self-checking scoreboard.
`timescale 1ns / 1ps

module tb_image_pixel_store_format_convert;
    import ipsfc_pkg::*;
    import ipsfc_tb_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;

    pixel_access_scoreboard sb;

    // sender and receiver pacing
    int tx_burst     = 0;
    int rx_burst     = 0;
    bit flood        = 1'b0;   // sender offers back to back
    bit hold_off_req = 1'b0;   // receiver stalls for a long stretch

    localparam int PHASES   = 14;
    localparam int PER_PHASE = 37;
    localparam int LONG_HOLD = 300;

    // width, height, bytes per pixel for each random phase; extremes included
    int phase_tab [PHASES][3] = '{
        '{8, 8, 4}, '{256, 256, 3}, '{1, 1, 1}, '{16, 4, 2}, '{0, 7, 4},
        '{9, 0, 1}, '{5, 6, 0}, '{3, 5, 7}, '{256, 2, 4}, '{1, 256, 2},
        '{12, 12, 3}, '{6, 10, 1}, '{4, 4, 5}, '{32, 16, 4}
    };

    image_pixel_store_format_convert i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // hard stop should the block hang
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic pixel_access_t acc_of(op_t op, int x, int y, logic [31:0] raw,
                                             logic [7:0] r, logic [7:0] g,
                                             logic [7:0] b, logic [7:0] a);
        pixel_access_t acc;
        acc.op = op; acc.x = x; acc.y = y; acc.raw = raw;
        acc.red = r; acc.green = g; acc.blue = b; acc.alpha = a;
        return acc;
    endfunction

    function automatic logic [7:0] colour_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    // random access; reads aim mostly at pixels already written
    function automatic pixel_access_t make_access();
        pixel_access_t acc;
        int            pick;
        int            w;
        int            h;
        int            idx;
        int            tries;
        w    = sb.width;
        h    = sb.height;
        pick = $urandom_range(0, 99);
        acc.op = pick < 40 ? OP_READ : pick < 65 ? OP_WRITE_RAW :
                 pick < 92 ? OP_WRITE_COLOR : OP_NOP;
        acc.raw   = $urandom;
        acc.red   = colour_byte();
        acc.green = colour_byte();
        acc.blue  = colour_byte();
        acc.alpha = colour_byte();
        pick = $urandom_range(0, 99);
        if (w * h > 0 && pick < 70) begin
            acc.x = $urandom_range(0, w - 1);
            acc.y = $urandom_range(0, h - 1);
            // same pixel reached through a column past the row end
            if (pick < 12 && acc.y > 0) begin
                acc.x += w;
                acc.y -= 1;
            end
        end else if (pick < 85) begin
            // just around the borders
            acc.x = int'($urandom_range(0, w + 3)) - 2;
            acc.y = int'($urandom_range(0, h + 3)) - 2;
        end else begin
            acc.x = int'($urandom_range(0, 1023)) - 512;
            acc.y = int'($urandom_range(0, 1023)) - 512;
        end
        if (acc.op == OP_READ && w * h > 0 && sb.filled_idx.size() > 0 &&
            $urandom_range(0, 3) != 0) begin
            for (tries = 0; tries < 6; tries++) begin
                idx = sb.filled_idx[$urandom_range(0, sb.filled_idx.size() - 1)];
                if (idx < w * h) begin
                    acc.x = idx % w;
                    acc.y = idx / w;
                    break;
                end
            end
        end
        // never read a pixel that holds nothing yet
        if (acc.op == OP_READ && sb.hits_unwritten(acc.x, acc.y))
            acc.op = OP_WRITE_RAW;
        return acc;
    endfunction

    // offer one access after a random gap; returns at the transfer edge
    task automatic send_access(input pixel_access_t acc);
        int gap;
        if (flood || tx_burst > 0) begin
            gap = 0;
            if (tx_burst > 0) tx_burst--;
        end else if ($urandom_range(0, 7) == 0) begin
            tx_burst = $urandom_range(8, 32);
            gap      = 0;
        end else begin
            gap = $urandom_range(0, 11);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= acc.op;
        s_tdata  <= {4'd0, acc.alpha, acc.blue, acc.green, acc.red, acc.raw,
                     acc.y[9:0], acc.x[9:0]};
        // ready is judged mid-cycle, when everything has settled
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        sb.note_access(acc);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [8:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        sb.set_reg(index, value);
    endtask

    task automatic set_format(input int w, input int h, input int comps);
        write_register(CFG_IMAGE_WIDTH, 9'(w));
        write_register(CFG_IMAGE_HEIGHT, 9'(h));
        write_register(CFG_PIXEL_COMPONENTS, 9'(comps));
        cfg_valid <= 1'b0;
    endtask

    // sender pauses until every predicted view has come back
    task automatic wait_all_views();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // result checker: a transfer happens at the edge after a mid-cycle valid and ready
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_view(m_tdata, m_tuser[0]);
    end

    // result receiver with random stalls and one long hold-off on request
    initial begin : result_sink
        int stall;
        while (!aresetn) @(negedge aclk);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall        = LONG_HOLD;
            end else if (rx_burst > 0) begin
                rx_burst--;
                stall = 0;
            end else if ($urandom_range(0, 7) == 0) begin
                rx_burst = $urandom_range(8, 32);
                stall    = 0;
            end else begin
                stall = $urandom_range(0, 11);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (!m_tvalid);
            @(posedge aclk);
        end
    end

    initial begin
        pixel_access_t acc;
        int            p;
        int            counted;
        int            spin;
        sb        = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_READ;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // RGBA: full and empty values, wrap to the previous row, borders, no-op code
        set_format(4, 3, FMT_RGBA);
        send_access(acc_of(OP_WRITE_RAW, 0, 0, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 8'h00));
        send_access(acc_of(OP_READ, 0, 0, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_access(acc_of(OP_WRITE_COLOR, 3, 2, 32'd0, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        send_access(acc_of(OP_READ, 3, 2, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_access(acc_of(OP_WRITE_RAW, -1, 1, 32'h1234_5678, 8'h00, 8'h00, 8'h00, 8'h00));
        send_access(acc_of(OP_READ, 3, 0, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_access(acc_of(OP_WRITE_COLOR, 1, 0, 32'd0, 8'h01, 8'h02, 8'h03, 8'h04));
        send_access(acc_of(OP_READ, -512, -512, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_access(acc_of(OP_READ, 511, 511, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_access(acc_of(OP_WRITE_RAW, 4, 2, 32'hDEAD_BEEF, 8'h00, 8'h00, 8'h00, 8'h00));
        send_access(acc_of(OP_NOP, 0, 0, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        wait_all_views();

        // gray: stored RGBA entry masked, mean rounds down
        set_format(4, 3, FMT_GRAY);
        send_access(acc_of(OP_READ, 0, 0, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_access(acc_of(OP_WRITE_COLOR, 2, 0, 32'd0, 8'h00, 8'h00, 8'h01, 8'h00));
        send_access(acc_of(OP_READ, 2, 0, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_access(acc_of(OP_WRITE_COLOR, 2, 1, 32'd0, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        send_access(acc_of(OP_READ, 2, 1, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        wait_all_views();

        set_format(4, 3, FMT_GRAY_ALPHA);
        send_access(acc_of(OP_WRITE_COLOR, 2, 2, 32'd0, 8'd10, 8'd20, 8'd30, 8'd99));
        send_access(acc_of(OP_READ, 2, 2, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_access(acc_of(OP_READ, 1, 0, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        wait_all_views();

        set_format(4, 3, FMT_RGB);
        send_access(acc_of(OP_WRITE_COLOR, 0, 1, 32'd0, 8'hFF, 8'h00, 8'h80, 8'h00));
        send_access(acc_of(OP_READ, 0, 1, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_access(acc_of(OP_READ, 3, 2, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        wait_all_views();

        // empty and unknown formats: writes dropped, reads give opaque black
        set_format(4, 3, 0);
        send_access(acc_of(OP_WRITE_RAW, 1, 1, 32'hCAFE_F00D, 8'h00, 8'h00, 8'h00, 8'h00));
        send_access(acc_of(OP_READ, 0, 0, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        wait_all_views();
        set_format(4, 3, 6);
        send_access(acc_of(OP_READ, 3, 2, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        wait_all_views();

        // largest image, far corner
        set_format(256, 256, FMT_RGBA);
        send_access(acc_of(OP_WRITE_RAW, 255, 255, 32'hA5A5_A5A5, 8'h00, 8'h00, 8'h00, 8'h00));
        send_access(acc_of(OP_READ, 255, 255, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        wait_all_views();

        // random phases, each under its own format
        for (p = 0; p < PHASES; p++) begin
            set_format(phase_tab[p][0], phase_tab[p][1], phase_tab[p][2]);
            // two phases start with the receiver held off and the sender flooding
            if (p == 3 || p == 10) begin
                flood        = 1'b1;
                hold_off_req = 1'b1;
            end
            counted = 0;
            while (counted < PER_PHASE) begin
                acc = make_access();
                send_access(acc);
                counted++;
                if (counted >= PER_PHASE / 2)
                    flood = 1'b0;
            end
            wait_all_views();
        end

        // bounded drain, then a few quiet cycles
        s_tvalid <= 1'b0;
        for (spin = 0; spin < 5000 && sb.pending() != 0; spin++)
            @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d views never arrived", sb.pending()));
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
